>>> design/b2da_pkg.sv
package b2da_pkg;

  localparam int unsigned VALUE_W          = 16;
  localparam int unsigned NUM_DIGITS       = 5;
  localparam int unsigned BCD_W            = 4 * NUM_DIGITS;
  localparam int unsigned NUM_STAGES       = 4;
  localparam int unsigned SHIFTS_PER_STAGE = VALUE_W / NUM_STAGES;
  localparam int unsigned IDX_W            = 3;

  localparam logic [7:0] ASCII_ZERO   = 8'd48;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  typedef logic [IDX_W-1:0] digit_idx_t;

  // binary bits still to shift in, and the decimal digits built so far
  typedef struct packed {
    logic [VALUE_W-1:0] bin;
    logic [BCD_W-1:0]   bcd;
  } dab_t;

  // one double-dabble step: add 3 to every digit of five or more, then shift left
  function automatic dab_t dab_shift(dab_t d);
    dab_t                       res;
    logic [BCD_W-1:0]           adj;
    logic [BCD_W+VALUE_W-1:0]   cat;
    adj = d.bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    cat = {adj, d.bin} << 1;
    res.bcd = cat[BCD_W+VALUE_W-1 -: BCD_W];
    res.bin = cat[VALUE_W-1:0];
    return res;
  endfunction

endpackage

>>> design/b2da_dabble_stage.sv
module b2da_dabble_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  b2da_pkg::dab_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output b2da_pkg::dab_t out_data
);
  import b2da_pkg::*;

  logic valid_r;
  dab_t data_r;
  dab_t data_nxt;

  always_comb begin
    data_nxt = in_data;
    for (int s = 0; s < SHIFTS_PER_STAGE; s++) begin
      data_nxt = dab_shift(data_nxt);
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> design/b2da_serializer.sv
module b2da_serializer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [b2da_pkg::BCD_W-1:0]  in_bcd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_character,
  output logic                        out_last
);
  import b2da_pkg::*;

  logic              valid_r;
  logic              nl_r;
  logic              nl_nxt;
  digit_idx_t        idx_r;
  digit_idx_t        idx_nxt;
  digit_idx_t        lead;
  logic [BCD_W-1:0]  bcd_r;
  logic [3:0]        digit;

  // most significant non-zero digit, or the units digit for zero
  always_comb begin
    lead = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (in_bcd[4*i +: 4] != 4'd0) begin
        lead = IDX_W'(i);
      end
    end
  end

  // a new value loads once the newline of the previous one is taken
  assign in_ready = !valid_r || (out_ready && nl_r);

  always_comb begin
    nl_nxt  = nl_r;
    idx_nxt = idx_r;
    if (in_ready) begin
      nl_nxt  = 1'b0;
      idx_nxt = lead;
    end else if (out_ready) begin
      if (idx_r == '0) begin
        nl_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      nl_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      nl_r <= nl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (in_ready && in_valid) begin
      bcd_r <= in_bcd;
    end
  end

  assign digit         = bcd_r[{idx_r, 2'b00} +: 4];
  assign out_valid     = valid_r;
  assign out_last      = nl_r;
  assign out_character = nl_r ? NEWLINE_CODE : ASCII_ZERO + {4'b0000, digit};

endmodule

>>> design/binary_to_decimal_ascii.sv
// Prints a 16-bit unsigned value as decimal ASCII text.
// Input channel: in_valid / in_ready / in_value, one value per word.
// Output channel: out_valid / out_ready / out_character / out_last. Each value
// gives its digits most significant first, leading zeros dropped (zero gives
// a single '0'), then a newline (10) with out_last set: 2 to 6 words.
// The binary-to-BCD conversion runs through four register stages of four
// double-dabble shifts each; a fifth register holds the digits and sends one
// character per cycle while the receiver is ready. The first character
// appears once the value has passed through every stage into that fifth
// register; that sender sets the sustained rate, while the stages keep taking
// new values until they fill, at most one value a cycle.
// When the receiver stalls, the current character holds and the stages back
// up behind it; in_ready falls only once every stage is full. Nothing is
// lost or repeated.
// Synchronous reset (rst_n low) empties every stage and drops out_valid; no
// other state is kept.
module binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_character,
  output logic        out_last
);
  import b2da_pkg::*;

  dab_t                  stg_data  [0:NUM_STAGES];
  logic [NUM_STAGES:0]   stg_valid;
  logic [NUM_STAGES:0]   stg_ready;

  assign stg_data[0].bin = in_value;
  assign stg_data[0].bcd = '0;
  assign stg_valid[0]    = in_valid;
  assign in_ready        = stg_ready[0];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    b2da_dabble_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_data   (stg_data[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  b2da_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (stg_valid[NUM_STAGES]),
    .in_ready      (stg_ready[NUM_STAGES]),
    .in_bcd        (stg_data[NUM_STAGES].bcd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

>>> design/b2da_checker.sv
module b2da_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_character,
  input logic       out_last
);
  import b2da_pkg::*;

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("output word changed while stalled");

  a_last_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_character == NEWLINE_CODE)
    else $error("last word is not a newline");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_character >= ASCII_ZERO && out_character <= ASCII_ZERO + 8'd9)
    else $error("non-last word is not a decimal digit");

  // a digit is always followed straight away by the rest of its value
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a value's characters");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

>>> bench/tb_binary_to_decimal_ascii.sv
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii;
  import b2da_pkg::*;

  localparam int unsigned RADIX       = 10;
  localparam int          STALL_LIMIT = 2000;
  localparam int          RANDOM_ITEMS = 137;
  localparam int          DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_character;
  logic               out_last;

  logic [VALUE_W-1:0] value_q[$];
  char_t              text_q[$];
  char_t              want;

  logic in_taken;
  logic out_taken;
  int   in_gap;
  int   out_wait;
  int   idle_cycles;
  int   values_sent;
  int   chars_checked;
  int   errors;
  int   len_seen[1:NUM_DIGITS];

  binary_to_decimal_ascii DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // digits most significant first, zero still gives one digit, then the newline
  function automatic void queue_decimal_text(logic [VALUE_W-1:0] value);
    logic [7:0]  digits[$];
    int unsigned v;
    v = value;
    do begin
      digits.push_front(ASCII_ZERO + 8'(v % RADIX));
      v = v / RADIX;
    end while (v != 0);
    len_seen[digits.size()]++;
    foreach (digits[i]) text_q.push_back('{character: digits[i], last: 1'b0});
    text_q.push_back('{character: NEWLINE_CODE, last: 1'b1});
  endfunction

  // mostly values of a chosen digit count, so short and long texts both show up
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 6))
      0:       return VALUE_W'($urandom_range(0, 9));
      1:       return VALUE_W'($urandom_range(10, 99));
      2:       return VALUE_W'($urandom_range(100, 999));
      3:       return VALUE_W'($urandom_range(1000, 9999));
      4:       return VALUE_W'($urandom_range(10000, 65535));
      5: begin
        // either side of a power of ten
        case ($urandom_range(0, 3))
          0:       return VALUE_W'(9 + $urandom_range(0, 1));
          1:       return VALUE_W'(99 + $urandom_range(0, 1));
          2:       return VALUE_W'(999 + $urandom_range(0, 1));
          default: return VALUE_W'(9999 + $urandom_range(0, 1));
        endcase
      end
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  // accept, check and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken    <= 1'b0;
      out_taken   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        if (text_q.size() == 0) begin
          $error("word with nothing pending: character %0d, last %0b",
                 out_character, out_last);
          errors++;
        end else begin
          want = text_q.pop_front();
          if (out_character !== want.character) begin
            $error("character: expected %0d, got %0d", want.character, out_character);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            errors++;
          end
        end
        chars_checked++;
      end
      if (in_valid && in_ready) begin
        queue_decimal_text(in_value);
        values_sent++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("binary_to_decimal_ascii test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // sender: a gap drawn at random before each value, with stretches of none
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (value_q.size() > 0) begin
        in_value <= value_q.pop_front();
        in_valid <= 1'b1;
        in_gap = (values_sent % 64 >= 40) ? 0 : $urandom_range(0, 11);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: a stall drawn at random per word, with stretches of none
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) out_wait = (chars_checked % 128 >= 96) ? 0 : $urandom_range(0, 11);
      if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [VALUE_W-1:0] directed[] = '{
      16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
      16'd9999, 16'd10000, 16'd65535, 16'd65534, 16'd32768, 16'h5555,
      16'hAAAA, 16'h00FF, 16'hFF00, 16'd12345, 16'd50000, 16'd59999,
      16'd60000, 16'd10009, 16'd0
    };
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_value      = '0;
    out_ready     = 1'b0;
    in_gap        = 0;
    out_wait      = 0;
    values_sent   = 0;
    chars_checked = 0;
    errors        = 0;
    foreach (len_seen[i]) len_seen[i] = 0;

    foreach (directed[i]) value_q.push_back(directed[i]);
    repeat (RANDOM_ITEMS) value_q.push_back(pick_value());

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all values in and every character back out
    do @(posedge clk);
    while (value_q.size() != 0 || in_valid || text_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (text_q.size() != 0) begin
      $error("%0d characters still pending at the end", text_q.size());
      errors++;
    end

    $display("sent %0d values, checked %0d characters", values_sent, chars_checked);
    $display("values by digit count 1..5: %0d %0d %0d %0d %0d",
             len_seen[1], len_seen[2], len_seen[3], len_seen[4], len_seen[5]);
    if (errors == 0) begin
      $display("binary_to_decimal_ascii test passed");
    end else begin
      $display("binary_to_decimal_ascii test failed");
    end
    $finish;
  end

endmodule
